// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rtlv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlv_pkg
// Types, widths and constants shared by the root velocity block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package rtlv_pkg;

	// Payload widths
	localparam int IN_W    = 16;
	localparam int OUT_W   = 20;
	localparam int DIFF_W  = IN_W + 1;
	localparam int GAIN_W  = 32;

	// Configuration port
	localparam int REG_COUNT = 6;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int PADDR_W   = REG_IDX_W + 3;
	localparam int PDATA_W   = 64;
	localparam logic [PDATA_W-1:0] CFG_RESET = 64'h0001_0000_0000_0000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEADING_COS,
		REG_HEADING_SIN,
		REG_TURN_RATE,
		REG_VEL_X,
		REG_VEL_Z,
		REG_HEIGHT
	} reg_idx_t;

	// Digit-serial multiply-add lanes
	localparam int LANES     = 6;
	localparam int DIGIT_W   = 8;
	localparam int DIGITS    = 3;
	localparam int LANE_VW   = DIGIT_W * DIGITS;
	localparam int ACC_W     = 56;
	localparam int LANE_COS  = 0;   // also the turn rate lane once the heading is known
	localparam int LANE_SIN  = 1;
	localparam int LANE_VX   = 2;
	localparam int LANE_VZ   = 3;
	localparam int LANE_HA   = 4;   // height of the held frame
	localparam int LANE_HB   = 5;   // height of the last frame
	localparam int MEAN_SH   = 12;
	localparam int OFF_SH    = 16;
	localparam int Q_SH      = 4;
	localparam int OUT_SHIFT = 20;
	localparam int OUT_ROUND = 524288;
	localparam int OUT_MAX   = 524287;
	localparam int OUT_MIN   = -524288;

	// CORDIC
	localparam int CW           = 52;
	localparam int ANG_W        = 16;
	localparam int ATAN_ENTRIES = 20;
	localparam int CNT_W        = $clog2(ATAN_ENTRIES);
	localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [ANG_W-1:0] HALF_TURN    = 16'h8000;

	// Heading difference to radians
	localparam int TWO_PI_Q16 = 411775;
	localparam int RAD_ROUND  = 32768;
	localparam int RAD_PROD_W = 37;
	localparam int RAD_SH     = 16;
	localparam int RAD_W      = RAD_PROD_W - RAD_SH;
	localparam logic signed [DIFF_W-1:0] HALF_TURN_POS = 17'sd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROT,
		ST_ITER,
		ST_DIFF,
		ST_TURN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] turn_rate_out;
		logic signed [OUT_W-1:0] vel_x_out;
		logic signed [OUT_W-1:0] vel_z_out;
		logic signed [OUT_W-1:0] height_out;
		logic                    last_result;
	} out_item_t;

	function automatic logic signed [GAIN_W-1:0] gain_of(input logic [PDATA_W-1:0] r);
		return r[PDATA_W-1:GAIN_W];
	endfunction

	function automatic logic signed [GAIN_W-1:0] offset_of(input logic [PDATA_W-1:0] r);
		return r[GAIN_W-1:0];
	endfunction

	// atan(2^-i) in binary angle units, one turn = 65536
	function automatic logic [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
		case (i)
			5'd0:    return 16'd8192;
			5'd1:    return 16'd4836;
			5'd2:    return 16'd2555;
			5'd3:    return 16'd1297;
			5'd4:    return 16'd651;
			5'd5:    return 16'd326;
			5'd6:    return 16'd163;
			5'd7:    return 16'd81;
			5'd8:    return 16'd41;
			5'd9:    return 16'd20;
			5'd10:   return 16'd10;
			5'd11:   return 16'd5;
			5'd12:   return 16'd3;
			5'd13:   return 16'd1;
			5'd14:   return 16'd1;
			default: return '0;
		endcase
	endfunction

	// Round off the Q.20 fraction and clamp to Q7.12
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-OUT_SHIFT-1:0] r;
		r = a[ACC_W-1:OUT_SHIFT];
		if (r > OUT_MAX)
			return OUT_W'(OUT_MAX);
		if (r < OUT_MIN)
			return OUT_W'(OUT_MIN);
		return r[OUT_W-1:0];
	endfunction

endpackage

// ===== src/rtlv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root velocity channel interfaces
// Valid/ready channels for pose frames in and velocity results out.
// ----------------------------------------------------------------------------
interface rtlv_in_if;
	import rtlv_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] x_norm;
	logic signed [IN_W-1:0] y_norm;
	logic signed [IN_W-1:0] z_norm;
	logic signed [IN_W-1:0] cos_norm;
	logic signed [IN_W-1:0] sin_norm;
	logic                   last_frame;

	modport source (
		output valid, x_norm, y_norm, z_norm, cos_norm, sin_norm, last_frame,
		input  ready
	);
	modport sink (
		input  valid, x_norm, y_norm, z_norm, cos_norm, sin_norm, last_frame,
		output ready
	);
endinterface

interface rtlv_out_if;
	import rtlv_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] turn_rate_out;
	logic signed [OUT_W-1:0] vel_x_out;
	logic signed [OUT_W-1:0] vel_z_out;
	logic signed [OUT_W-1:0] height_out;
	logic                    last_result;

	modport source (
		output valid, turn_rate_out, vel_x_out, vel_z_out, height_out, last_result,
		input  ready
	);
	modport sink (
		input  valid, turn_rate_out, vel_x_out, vel_z_out, height_out, last_result,
		output ready
	);
endinterface

// ===== src/root_trajectory_to_local_velocity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root trajectory to local velocity
// Turns a stream of global root poses into heading rate, planar velocity and
// height per frame, using a CORDIC atan2 and digit-serial multiply-adds.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------
//  frame    | in  | valid / ready  | x, y, z, cos, sin (Q3.12), last_frame
//  result   | out | valid / ready  | turn, vel x, vel z, height (Q7.12), last
//  apb      | in  | psel / penable | six 64-bit gain and offset registers
//
// A frame is worked in order: the multiply-adds in three 8-bit digits, one
// quadrant turn, one CORDIC step a cycle, the heading difference and the
// turn rate in three more digits; then its results go into the queue. A
// new frame is taken only once the previous one is queued.
// Reset clears the held frame and returns every register to gain 1.0,
// offset 0. A two-entry output queue holds results while result.ready is low.
// ----------------------------------------------------------------------------
module root_trajectory_to_local_velocity #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rtlv_in_if.sink                        frame,
	rtlv_out_if.source                     result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rtlv_pkg::PADDR_W-1:0]   paddr,
	input  logic [rtlv_pkg::PDATA_W-1:0]   pwdata,
	output logic [rtlv_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import rtlv_pkg::*;

	localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(STEPS - 1);
	localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [PDATA_W-1:0]   cfg_q [REG_COUNT];
	logic [REG_IDX_W-1:0] reg_sel;
	logic                 reg_hit;
	logic                 cfg_wr;

	assign reg_sel = paddr[PADDR_W-1:3];
	assign reg_hit = (reg_sel < REG_IDX_W'(REG_COUNT));
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? cfg_q[reg_sel] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < REG_COUNT; r++)
				cfg_q[r] <= CFG_RESET;
		end else if (cfg_wr && reg_hit) begin
			cfg_q[reg_sel] <= pwdata;
		end
	end

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             take, mul_step, turn_step, rot_en, iter_en, diff_en, push;
	logic             cnt_run, cnt_wrap;
	logic             pend1_q, pend2_q;
	logic             q_space;
	logic             have_prev_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (frame.valid) state_d = ST_MUL;
			ST_MUL:  if (cnt_q == LAST_DIGIT) state_d = ST_ROT;
			ST_ROT:  state_d = ST_ITER;
			ST_ITER: if (cnt_q == LAST_STEP) state_d = ST_DIFF;
			ST_DIFF: state_d = ST_TURN;
			ST_TURN: if (cnt_q == LAST_DIGIT) state_d = ST_EMIT;
			ST_EMIT: begin
				// leave once the final pending result goes into the queue, or at once if none is pending
				if (!(pend1_q || pend2_q) || (q_space && !(pend1_q && pend2_q)))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take      = 1'b0;
		mul_step  = 1'b0;
		turn_step = 1'b0;
		rot_en    = 1'b0;
		iter_en   = 1'b0;
		diff_en   = 1'b0;
		push      = 1'b0;
		cnt_wrap  = 1'b0;
		case (state_q)
			ST_IDLE: take = frame.valid;
			ST_MUL: begin
				mul_step = 1'b1;
				cnt_wrap = (cnt_q == LAST_DIGIT);
			end
			ST_ROT:  rot_en = 1'b1;
			ST_ITER: begin
				iter_en  = 1'b1;
				cnt_wrap = (cnt_q == LAST_STEP);
			end
			ST_DIFF: diff_en = 1'b1;
			ST_TURN: begin
				turn_step = 1'b1;
				cnt_wrap  = (cnt_q == LAST_DIGIT);
			end
			ST_EMIT: push = q_space && (pend1_q || pend2_q);
			default: ;
		endcase
		cnt_run = mul_step || iter_en || turn_step;
	end

	assign frame.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend1_q <= 1'b0;
			pend2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_wrap)
				cnt_q <= '0;
			else if (cnt_run)
				cnt_q <= cnt_q + 1'b1;
			if (take) begin
				pend1_q <= have_prev_q;
				pend2_q <= frame.last_frame;
			end else if (push) begin
				if (pend1_q)
					pend1_q <= 1'b0;
				else
					pend2_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Held frame
	// ------------------------------------------------------------------
	logic signed [IN_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [ANG_W-1:0]       prev_h_q;
	logic signed [IN_W-1:0] x_q, y_q, z_q;
	logic [ANG_W-1:0]       heading;

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= frame.x_norm;
			y_q <= frame.y_norm;
			z_q <= frame.z_norm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			prev_h_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (diff_en) begin
			// a last frame closes the run; otherwise hold this frame
			if (pend2_q) begin
				have_prev_q <= 1'b0;
			end else begin
				prev_x_q    <= x_q;
				prev_y_q    <= y_q;
				prev_z_q    <= z_q;
				prev_h_q    <= heading;
				have_prev_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0] acc_q [LANES];
	logic signed [CW-1:0]    cx_q, cy_q, x0, y0, xs, ys;
	logic [ANG_W-1:0]        cz_q;
	logic                    zero_q;

	assign x0 = acc_q[LANE_COS][CW-1:0];
	assign y0 = acc_q[LANE_SIN][CW-1:0];
	assign xs = cx_q >>> cnt_q;
	assign ys = cy_q >>> cnt_q;

	always_ff @(posedge clk) begin
		if (rot_en) begin
			zero_q <= (x0 == '0) && (y0 == '0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					cx_q <= y0;
					cy_q <= -x0;
					cz_q <= QUARTER_TURN;
				end else begin
					cx_q <= -y0;
					cy_q <= x0;
					cz_q <= '0 - QUARTER_TURN;
				end
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (iter_en) begin
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_entry(cnt_q);
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_entry(cnt_q);
			end
		end
	end

	// ------------------------------------------------------------------
	// Heading difference to radians (Q.16)
	// ------------------------------------------------------------------
	logic [ANG_W-1:0]              hdiff;
	logic signed [DIFF_W-1:0]      dth;
	logic signed [RAD_PROD_W-1:0]  rad_prod;
	logic signed [RAD_W-1:0]       rad;

	assign heading = zero_q ? '0 : cz_q;
	assign hdiff   = heading - prev_h_q;

	always_comb begin
		if (!have_prev_q)
			dth = '0;
		else if (hdiff == HALF_TURN)
			dth = HALF_TURN_POS;
		else
			dth = DIFF_W'($signed(hdiff));
		rad_prod = RAD_PROD_W'(dth) * RAD_PROD_W'(TWO_PI_Q16) + RAD_PROD_W'(RAD_ROUND);
		rad      = rad_prod[RAD_PROD_W-1:RAD_SH];
	end

	// ------------------------------------------------------------------
	// Digit-serial multiply-add lanes
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]   mcand_q    [LANES];
	logic signed [LANE_VW-1:0] dig_q      [LANES];
	logic signed [ACC_W-1:0]   acc_init   [LANES];
	logic signed [ACC_W-1:0]   mcand_init [LANES];
	logic signed [LANE_VW-1:0] dig_init   [LANES];
	logic signed [DIGIT_W:0]   dsel       [LANES];
	logic [LANES-1:0]          lane_load, lane_step;
	logic signed [DIFF_W-1:0]  dx, dz;

	always_comb begin
		if (have_prev_q) begin
			dx = DIFF_W'(frame.x_norm) - DIFF_W'(prev_x_q);
			dz = DIFF_W'(frame.z_norm) - DIFF_W'(prev_z_q);
		end else begin
			dx = '0;
			dz = '0;
		end

		if (diff_en) begin
			acc_init[LANE_COS]   = (ACC_W'(offset_of(cfg_q[REG_TURN_RATE])) <<< OFF_SH)
				+ ACC_W'(OUT_ROUND);
			mcand_init[LANE_COS] = ACC_W'(gain_of(cfg_q[REG_TURN_RATE]));
			dig_init[LANE_COS]   = LANE_VW'(rad);
		end else begin
			acc_init[LANE_COS]   = ACC_W'(offset_of(cfg_q[REG_HEADING_COS])) <<< MEAN_SH;
			mcand_init[LANE_COS] = ACC_W'(gain_of(cfg_q[REG_HEADING_COS]));
			dig_init[LANE_COS]   = LANE_VW'(frame.cos_norm);
		end

		acc_init[LANE_SIN]   = ACC_W'(offset_of(cfg_q[REG_HEADING_SIN])) <<< MEAN_SH;
		mcand_init[LANE_SIN] = ACC_W'(gain_of(cfg_q[REG_HEADING_SIN]));
		dig_init[LANE_SIN]   = LANE_VW'(frame.sin_norm);

		acc_init[LANE_VX]   = (ACC_W'(offset_of(cfg_q[REG_VEL_X])) <<< OFF_SH)
			+ ACC_W'(OUT_ROUND);
		mcand_init[LANE_VX] = ACC_W'(gain_of(cfg_q[REG_VEL_X]));
		dig_init[LANE_VX]   = LANE_VW'(dx) <<< Q_SH;

		acc_init[LANE_VZ]   = (ACC_W'(offset_of(cfg_q[REG_VEL_Z])) <<< OFF_SH)
			+ ACC_W'(OUT_ROUND);
		mcand_init[LANE_VZ] = ACC_W'(gain_of(cfg_q[REG_VEL_Z]));
		dig_init[LANE_VZ]   = LANE_VW'(dz) <<< Q_SH;

		acc_init[LANE_HA]   = (ACC_W'(offset_of(cfg_q[REG_HEIGHT])) <<< OFF_SH)
			+ ACC_W'(OUT_ROUND);
		mcand_init[LANE_HA] = ACC_W'(gain_of(cfg_q[REG_HEIGHT]));
		dig_init[LANE_HA]   = LANE_VW'(prev_y_q) <<< Q_SH;

		acc_init[LANE_HB]   = acc_init[LANE_HA];
		mcand_init[LANE_HB] = mcand_init[LANE_HA];
		dig_init[LANE_HB]   = LANE_VW'(frame.y_norm) <<< Q_SH;

		lane_load           = {LANES{take}};
		lane_load[LANE_COS] = take || diff_en;
		lane_step           = {LANES{mul_step}};
		lane_step[LANE_COS] = mul_step || turn_step;

		// low digits are unsigned, the top digit carries the sign
		for (int l = 0; l < LANES; l++)
			dsel[l] = {(cnt_q == LAST_DIGIT) ? dig_q[l][DIGIT_W-1] : 1'b0,
				dig_q[l][DIGIT_W-1:0]};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (lane_load[l]) begin
				acc_q[l]   <= acc_init[l];
				mcand_q[l] <= mcand_init[l];
				dig_q[l]   <= dig_init[l];
			end else if (lane_step[l]) begin
				acc_q[l]   <= acc_q[l] + ACC_W'(mcand_q[l] * dsel[l]);
				mcand_q[l] <= mcand_q[l] <<< DIGIT_W;
				dig_q[l]   <= dig_q[l] >>> DIGIT_W;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output queue
	// ------------------------------------------------------------------
	out_item_t  q_mem [2];
	out_item_t  item_a, item_b;
	logic       q_wr_q, q_rd_q;
	logic [1:0] q_cnt_q;
	logic       pop;

	always_comb begin
		item_a.turn_rate_out = sat_out(acc_q[LANE_COS]);
		item_a.vel_x_out     = sat_out(acc_q[LANE_VX]);
		item_a.vel_z_out     = sat_out(acc_q[LANE_VZ]);
		item_a.height_out    = sat_out(acc_q[LANE_HA]);
		item_a.last_result   = 1'b0;
		item_b               = item_a;
		item_b.height_out    = sat_out(acc_q[LANE_HB]);
		item_b.last_result   = 1'b1;
	end

	assign q_space = (q_cnt_q != 2'd2);
	assign pop     = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push)
			q_mem[q_wr_q] <= pend1_q ? item_a : item_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			if (push)
				q_wr_q <= ~q_wr_q;
			if (pop)
				q_rd_q <= ~q_rd_q;
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign result.valid         = (q_cnt_q != '0);
	assign result.turn_rate_out = q_mem[q_rd_q].turn_rate_out;
	assign result.vel_x_out     = q_mem[q_rd_q].vel_x_out;
	assign result.vel_z_out     = q_mem[q_rd_q].vel_z_out;
	assign result.height_out    = q_mem[q_rd_q].height_out;
	assign result.last_result   = q_mem[q_rd_q].last_result;

endmodule

// ===== src/rtlv_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rtlv_checker
// Port-level checks on the root velocity block: one frame at a time, no
// result unowed, a stalled result stays valid with height and last held.
// ----------------------------------------------------------------------------
module rtlv_checker (
	input  logic        clk,
	input  logic        arst_n,
	rtlv_in_if.sink     frame,
	rtlv_out_if.source  result
);
	logic       open_q;
	logic [2:0] owed_q;
	logic       f_xfer, r_xfer;
	logic [2:0] owed_add;

	assign f_xfer   = frame.valid && frame.ready;
	assign r_xfer   = result.valid && result.ready;
	// a frame after an open one owes a result, a last frame owes one more
	assign owed_add = f_xfer ? ({2'b0, open_q} + {2'b0, frame.last_frame}) : 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			owed_q <= '0;
		end else begin
			if (f_xfer)
				open_q <= !frame.last_frame;
			owed_q <= owed_q + owed_add - {2'b0, r_xfer};
		end
	end

	`ASSERT_NEXT(a_one_frame_at_a_time, clk, arst_n, f_xfer, !frame.ready, "frame taken while busy")
	`ASSERT_SAME(a_result_owed, clk, arst_n, result.valid, owed_q != 3'd0, "result with no frame owing it")
	`ASSERT_NEXT(a_result_held, clk, arst_n, result.valid && !result.ready, result.valid && $stable(result.height_out) && $stable(result.last_result), "stalled result dropped or changed")

endmodule

bind root_trajectory_to_local_velocity rtlv_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.frame  (frame),
	.result (result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the root trajectory block. Pose frames go in as
// runs closed by a last frame, under several gain and offset settings, with
// random gaps on both channels and one long hold on the result side. Each
// accepted frame is predicted here: heading, differences and saturated
// outputs. Every result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import rtlv_pkg::*;

	localparam int CORDIC_STEPS  = 14;
	localparam int SETTLE_CYCLES = CORDIC_STEPS + 16;
	localparam int STALL_CYCLES  = 400;
	localparam int PHASE_POSES   = 120;

	typedef struct packed {
		logic signed [IN_W-1:0] x_norm;
		logic signed [IN_W-1:0] y_norm;
		logic signed [IN_W-1:0] z_norm;
		logic signed [IN_W-1:0] cos_norm;
		logic signed [IN_W-1:0] sin_norm;
		logic                   last_frame;
	} pose_t;

	typedef enum int {
		SET_RESET,
		SET_MODERATE,
		SET_RANDOM,
		SET_MAX,
		SET_MIN,
		SET_ZERO,
		SET_ONES
	} setting_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	rtlv_in_if  frame ();
	rtlv_out_if result ();

	root_trajectory_to_local_velocity #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Own copy of the registers and of the held frame
	logic [PDATA_W-1:0]     affine [REG_COUNT];
	logic signed [IN_W-1:0] held_x;
	logic signed [IN_W-1:0] held_y;
	logic signed [IN_W-1:0] held_z;
	logic [ANG_W-1:0]       held_heading;
	bit                     holding;

	int arc_tab [ATAN_ENTRIES] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0, 0, 0, 0, 0};

	out_item_t pending_results [$];
	int        mismatches;
	int        poses_sent;
	int        tx_max_gap;
	int        rx_max_gap;
	int        rx_wait;
	int        stall_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [ANG_W-1:0] heading_of(input logic signed [IN_W-1:0] c,
		input logic signed [IN_W-1:0] s);
		logic signed [GAIN_W-1:0] c_scale;
		logic signed [GAIN_W-1:0] c_mean;
		logic signed [GAIN_W-1:0] s_scale;
		logic signed [GAIN_W-1:0] s_mean;
		longint                   x;
		longint                   y;
		longint                   z;
		longint                   t;
		longint                   xs;
		int                       i;
		c_scale = affine[REG_HEADING_COS][63:32];
		c_mean  = affine[REG_HEADING_COS][31:0];
		s_scale = affine[REG_HEADING_SIN][63:32];
		s_mean  = affine[REG_HEADING_SIN][31:0];
		x = longint'(c) * longint'(c_scale) + longint'(c_mean) * 4096;
		y = longint'(s) * longint'(s_scale) + longint'(s_mean) * 4096;
		if (x == 0 && y == 0)
			return '0;
		z = 0;
		// bring the vector into the right half-plane first
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 16384;
			end else begin
				x = -y;
				y = t;
				z = -16384;
			end
		end
		for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
			xs = x >>> i;
			if (y >= 0) begin
				x = x + (y >>> i);
				y = y - xs;
				z = z + arc_tab[i];
			end else begin
				x = x - (y >>> i);
				y = y + xs;
				z = z - arc_tab[i];
			end
		end
		return z[ANG_W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] scaled(input logic [PDATA_W-1:0] r,
		input longint v);
		logic signed [GAIN_W-1:0] gain;
		logic signed [GAIN_W-1:0] bias;
		longint                   q;
		gain = r[63:32];
		bias = r[31:0];
		q = (v * longint'(gain) + longint'(bias) * 65536 + 524288) >>> 20;
		if (q > OUT_MAX)
			q = OUT_MAX;
		else if (q < OUT_MIN)
			q = OUT_MIN;
		return q[OUT_W-1:0];
	endfunction

	function automatic out_item_t frame_result(input longint turn, input longint dx,
		input longint dz, input logic signed [IN_W-1:0] height, input bit last);
		out_item_t r;
		r.turn_rate_out = scaled(affine[REG_TURN_RATE], (turn * TWO_PI_Q16 + RAD_ROUND) >>> 16);
		r.vel_x_out     = scaled(affine[REG_VEL_X], dx * 16);
		r.vel_z_out     = scaled(affine[REG_VEL_Z], dz * 16);
		r.height_out    = scaled(affine[REG_HEIGHT], longint'(height) * 16);
		r.last_result   = last;
		return r;
	endfunction

	task automatic predict_pose(input pose_t p);
		logic [ANG_W-1:0]       h;
		logic signed [ANG_W-1:0] step;
		longint                 turn;
		longint                 dx;
		longint                 dz;
		h = heading_of(p.cos_norm, p.sin_norm);
		if (holding) begin
			step = h - held_heading;
			// half a turn counts as +pi
			turn = (step == -32768) ? 32768 : longint'(step);
			dx = longint'(p.x_norm) - longint'(held_x);
			dz = longint'(p.z_norm) - longint'(held_z);
			pending_results.push_back(frame_result(turn, dx, dz, held_y, 1'b0));
			if (p.last_frame)
				pending_results.push_back(frame_result(turn, dx, dz, p.y_norm, 1'b1));
		end else if (p.last_frame) begin
			pending_results.push_back(frame_result(0, 0, 0, p.y_norm, 1'b1));
		end
		if (p.last_frame) begin
			holding = 1'b0;
		end else begin
			held_x       = p.x_norm;
			held_y       = p.y_norm;
			held_z       = p.z_norm;
			held_heading = h;
			holding      = 1'b1;
		end
	endtask

	function automatic pose_t pose(input int x, input int y, input int z, input int c,
		input int s, input bit last);
		pose_t p;
		p.x_norm     = 16'(x);
		p.y_norm     = 16'(y);
		p.z_norm     = 16'(z);
		p.cos_norm   = 16'(c);
		p.sin_norm   = 16'(s);
		p.last_frame = last;
		return p;
	endfunction

	task automatic send_pose(input pose_t p);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			frame.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame.valid      <= 1'b1;
		frame.x_norm     <= p.x_norm;
		frame.y_norm     <= p.y_norm;
		frame.z_norm     <= p.z_norm;
		frame.cos_norm   <= p.cos_norm;
		frame.sin_norm   <= p.sin_norm;
		frame.last_frame <= p.last_frame;
		@(posedge clk);
		while (!frame.ready)
			@(posedge clk);
		predict_pose(p);
		poses_sent++;
	endtask

	task automatic send_run(input int len, input bit smooth);
		pose_t p;
		int    k;
		p = pose($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
		for (k = 0; k < len; k++) begin
			if (k != 0) begin
				if (smooth) begin
					p.x_norm   = p.x_norm + 16'($urandom_range(0, 512)) - 16'd256;
					p.y_norm   = p.y_norm + 16'($urandom_range(0, 128)) - 16'd64;
					p.z_norm   = p.z_norm + 16'($urandom_range(0, 512)) - 16'd256;
					p.cos_norm = p.cos_norm + 16'($urandom_range(0, 1024)) - 16'd512;
					p.sin_norm = p.sin_norm + 16'($urandom_range(0, 1024)) - 16'd512;
				end else begin
					p = pose($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
				end
			end
			if ($urandom_range(0, 15) == 0) begin
				p.cos_norm = '0;
				p.sin_norm = '0;
			end
			p.last_frame = (k == len - 1);
			send_pose(p);
		end
	endtask

	task automatic write_affine(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		affine[idx] = value;
		// leave the bus idle before the next setup
		@(posedge clk);
	endtask

	task automatic load_setting(input setting_t kind);
		logic [PDATA_W-1:0] v;
		int                 i;
		for (i = 0; i < REG_COUNT; i++) begin
			case (kind)
				SET_RESET:    v = CFG_RESET;
				SET_MODERATE: v = {32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
					32'($urandom_range(0, 1 << 20)) - 32'(1 << 19)};
				SET_RANDOM:   v = {$urandom, $urandom};
				SET_MAX:      v = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
				SET_MIN:      v = {32'h8000_0000, 32'h8000_0000};
				SET_ZERO:     v = '0;
				default:      v = '1;
			endcase
			write_affine(reg_idx_t'(i), v);
		end
	endtask

	// Drop valid, wait for every predicted result, then let a frame with no
	// result finish its heading before anything else touches the registers
	task automatic settle();
		frame.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_field(input string field, input longint want, input longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	// Runs of one frame each, with random gaps, with the field extremes
	task automatic test_single_frame_runs();
		tx_max_gap = 19;
		rx_max_gap = 19;
		send_pose(pose(32767, -32768, 32767, 0, 0, 1'b1));
		send_pose(pose(-32768, 32767, -32768, -32768, -32768, 1'b1));
		settle();
	endtask

	task automatic test_field_extremes();
		send_pose(pose(-32768, -32768, -32768, 32767, 32767, 1'b0));
		send_pose(pose(32767, 32767, 32767, -32768, -32768, 1'b0));
		send_pose(pose(-32768, 0, -32768, -32768, 32767, 1'b0));
		send_pose(pose(0, -1, 0, -32768, 0, 1'b0));
		send_pose(pose(0, -1, 0, 32767, -32768, 1'b0));
		send_pose(pose(0, 0, 0, 0, 0, 1'b0));
		send_pose(pose(1, 1, 1, -1, 0, 1'b1));
		settle();
	endtask

	task automatic test_half_turn();
		logic [ANG_W-1:0]       target;
		logic signed [IN_W-1:0] opp_c;
		logic signed [IN_W-1:0] opp_s;
		bit                     found;
		int                     ci;
		int                     si;
		// find a pose pointing exactly opposite to (1.0, 0)
		target = heading_of(16'sd4096, 16'sd0) + HALF_TURN;
		opp_c  = 16'sh8000;
		opp_s  = '0;
		found  = 1'b0;
		for (ci = 0; ci < 4; ci++)
			for (si = -400; si <= 400; si++)
				if (!found && heading_of(16'(-32768 + 4096 * ci), 16'(si)) == target) begin
					opp_c = 16'(-32768 + 4096 * ci);
					opp_s = 16'(si);
					found = 1'b1;
				end
		send_pose(pose(0, 0, 0, 4096, 0, 1'b0));
		send_pose(pose(0, 0, 0, opp_c, opp_s, 1'b1));
		send_pose(pose(0, 0, 0, opp_c, opp_s, 1'b0));
		send_pose(pose(100, 50, -100, 4096, 0, 1'b1));
		settle();
	endtask

	task automatic test_setting_sweep();
		setting_t order [11] = '{SET_RESET, SET_MODERATE, SET_RANDOM, SET_MAX, SET_MIN,
			SET_MODERATE, SET_ZERO, SET_ONES, SET_RANDOM, SET_MODERATE, SET_RESET};
		int       i;
		int       stop;
		int       len;
		for (i = 0; i < 11; i++) begin
			load_setting(order[i]);
			case (i % 4)
				0: begin
					tx_max_gap = 19;
					rx_max_gap = 19;
				end
				1: begin
					tx_max_gap = 0;
					rx_max_gap = 0;
				end
				2: begin
					tx_max_gap = 19;
					rx_max_gap = 0;
				end
				default: begin
					tx_max_gap = 0;
					rx_max_gap = 19;
				end
			endcase
			stop = poses_sent + PHASE_POSES;
			while (poses_sent < stop) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
				send_run(len, $urandom_range(0, 3) != 0);
			end
			settle();
		end
	endtask

	// Hold the result side off while frames keep coming, so the block fills
	task automatic test_backpressure();
		load_setting(SET_MODERATE);
		tx_max_gap = 0;
		rx_max_gap = 0;
		stall_count <= STALL_CYCLES;
		repeat (6) send_run(6, 1'b1);
		settle();
	endtask

	always @(posedge clk)
		if (stall_count != 0)
			stall_count <= stall_count - 1;

	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready)
				rx_wait = $urandom_range(0, rx_max_gap);
			if (stall_count != 0) begin
				result.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				result.ready <= 1'b0;
				rx_wait--;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transfer with nothing pending", $time);
			end else begin
				want = pending_results.pop_front();
				if (result.turn_rate_out !== want.turn_rate_out)
					report_field("turn_rate_out", want.turn_rate_out, result.turn_rate_out);
				if (result.vel_x_out !== want.vel_x_out)
					report_field("vel_x_out", want.vel_x_out, result.vel_x_out);
				if (result.vel_z_out !== want.vel_z_out)
					report_field("vel_z_out", want.vel_z_out, result.vel_z_out);
				if (result.height_out !== want.height_out)
					report_field("height_out", want.height_out, result.height_out);
				if (result.last_result !== want.last_result)
					report_field("last_result", want.last_result, result.last_result);
			end
		end
	end

	initial begin
		#15_000_000;
		$display("[root_trajectory_to_local_velocity] ERROR");
		$finish;
	end

	initial begin
		int i;
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		frame.valid      <= 1'b0;
		frame.x_norm     <= '0;
		frame.y_norm     <= '0;
		frame.z_norm     <= '0;
		frame.cos_norm   <= '0;
		frame.sin_norm   <= '0;
		frame.last_frame <= 1'b0;
		for (i = 0; i < REG_COUNT; i++)
			affine[i] = CFG_RESET;
		held_x       = '0;
		held_y       = '0;
		held_z       = '0;
		held_heading = '0;
		holding      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_frame_runs();
		test_field_extremes();
		test_half_turn();
		test_setting_sweep();
		test_backpressure();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[root_trajectory_to_local_velocity] OK");
		end else begin
			if (pending_results.size() != 0)
				$display("%0d results never arrived", pending_results.size());
			$display("[root_trajectory_to_local_velocity] ERROR");
		end
		$finish;
	end

endmodule

// ===== root_trajectory_to_local_velocity.f =====
+incdir+src
src/rtlv_pkg.sv
src/rtlv_if.sv
src/root_trajectory_to_local_velocity.sv
src/rtlv_checker.sv
tb/tb.sv
